/* rtl/mkah_pkg.sv */
package mkah_pkg;

  localparam logic FuncFeed   = 1'b0;
  localparam logic FuncFinish = 1'b1;

  localparam logic [7:0] ByteEsc     = 8'h1B;
  localparam logic [7:0] ByteBracket = 8'h5B;
  localparam logic [7:0] ByteEm      = 8'h6D;
  localparam logic [7:0] ByteTick    = 8'h60;
  localparam logic [7:0] ByteStar    = 8'h2A;
  localparam logic [7:0] ByteUnder   = 8'h5F;
  localparam logic [7:0] ByteNewline = 8'h0A;

  localparam logic [7:0] CodeReset = 8'h30;
  localparam logic [7:0] CodeBold  = 8'h31;
  localparam logic [7:0] CodeDim   = 8'h32;

  // Most tokens one item can produce: a lone asterisk decided, then an underscore.
  localparam int unsigned TokMax = 8;

  // A token is either one literal byte or a four-byte SGR escape carrying its code.
  typedef struct packed {
    logic       esc;
    logic [7:0] chr;
  } tok_t;

  typedef struct packed {
    tok_t [TokMax-1:0] tok;
    logic [3:0]        cnt;
  } job_t;

  localparam tok_t TokDim   = '{esc: 1'b1, chr: CodeDim};
  localparam tok_t TokBold  = '{esc: 1'b1, chr: CodeBold};
  localparam tok_t TokReset = '{esc: 1'b1, chr: CodeReset};
  localparam tok_t TokTick  = '{esc: 1'b0, chr: ByteTick};
  localparam tok_t TokStar  = '{esc: 1'b0, chr: ByteStar};
  localparam tok_t TokUnder = '{esc: 1'b0, chr: ByteUnder};

endpackage

/* rtl/markdown_ansi_highlighter.sv */
// Markdown highlighter: inserts ANSI SGR escapes around lightweight markdown.
// Input channel (in_valid_i/in_ready_o): func_i = 0 feeds data_byte_i, func_i = 1
// finishes the stream (flushes a held run, closes open modes with a reset).
// Output channel (out_valid_o/out_ready_i): one byte per transfer on out_byte_o;
// last_o marks the final byte caused by one input item. Items that produce
// no byte (a held backtick or asterisk run, a finish with color off or with
// nothing to flush or close) give none. cfg_we_i/cfg_data_i write color_enable;
// 0 passes bytes through unchanged. Throughput: one output byte per cycle while
// out_ready_i is high, set by the back-end byte sequencer, which stays on an
// item until all of its bytes are out (up to 26, escapes are 4 bytes). Plain
// text therefore flows at one item per cycle. A two-entry queue of decoded
// items sits between the classifier and the sequencer, so input keeps flowing
// during short stalls and backs off once the queue is full.
// Reset: color enabled, no run held, no mode open, line start set, queue and
// output register empty. When the receiver stalls the output byte holds and
// the queue fills, after which in_ready_o drops.
module markdown_ansi_highlighter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic           push;
  mkah_pkg::job_t push_job;
  logic           q_ready;
  logic           q_valid;
  mkah_pkg::job_t head;
  logic           pop;

  mkah_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .job_o       (push_job)
  );

  mkah_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (head),
    .pop_i      (pop)
  );

  mkah_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_ready)
    else $error("push into a full queue");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from an empty queue");

  a_job_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.cnt != 4'd0) && (push_job.cnt <= 4'd8))
    else $error("pushed job has a bad token count");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && last_o)
    else $error("job finished without a last byte");
`endif

endmodule

/* rtl/mkah_front.sv */
module mkah_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output mkah_pkg::job_t    job_o
);

  logic       color_q;
  logic       hb_q, hb_d;
  logic [1:0] hc_q, hc_d;
  logic       hl_q, hl_d;
  logic       ls_q, ls_d;
  logic       bo_q, bo_d;
  logic       io_q, io_d;
  logic       co_q, co_d;

  mkah_pkg::job_t job_d;
  logic [3:0]     cnt;
  logic           dec;
  logic           skip;
  logic [7:0]     held_char;
  logic [1:0]     held_max;
  logic           accept;

  assign accept     = in_valid_i && q_ready_i;
  assign in_ready_o = q_ready_i;

  always_comb begin
    hb_d = hb_q;
    hc_d = hc_q;
    hl_d = hl_q;
    ls_d = ls_q;
    bo_d = bo_q;
    io_d = io_q;
    co_d = co_q;
    job_d = '0;
    cnt = '0;
    dec = 1'b0;
    skip = 1'b0;
    held_char = hb_q ? mkah_pkg::ByteTick : mkah_pkg::ByteStar;
    held_max = hb_q ? 2'd3 : 2'd2;

    if (color_q) begin
      if (func_i == mkah_pkg::FuncFeed) begin
        if (hc_d != 2'd0) begin
          if (data_byte_i == held_char && hc_d < held_max) begin
            // extend the held run; decide only once it is full
            hc_d = hc_d + 2'd1;
            skip = 1'b1;
            dec = (hc_d == held_max);
          end else begin
            dec = 1'b1;
          end
        end
      end else begin
        dec = 1'b1;
      end
    end

    if (dec && hc_d != 2'd0) begin
      if (hb_d) begin
        if (hc_d == 2'd3 && hl_d && !io_d) begin
          if (!co_d) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokDim;  cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
            co_d = 1'b1;
          end else begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick;  cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick;  cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick;  cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokReset; cnt = cnt + 4'd1;
            co_d = 1'b0;
            if (bo_d) begin
              job_d.tok[cnt[2:0]] = mkah_pkg::TokBold; cnt = cnt + 4'd1;
            end
            if (io_d || co_d) begin
              job_d.tok[cnt[2:0]] = mkah_pkg::TokDim; cnt = cnt + 4'd1;
            end
          end
        end else if (co_d || hc_d != 2'd1) begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
          if (hc_d >= 2'd2) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
          end
          if (hc_d == 2'd3) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
          end
        end else if (!io_d) begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokDim;  cnt = cnt + 4'd1;
          job_d.tok[cnt[2:0]] = mkah_pkg::TokTick; cnt = cnt + 4'd1;
          io_d = 1'b1;
        end else begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokTick;  cnt = cnt + 4'd1;
          job_d.tok[cnt[2:0]] = mkah_pkg::TokReset; cnt = cnt + 4'd1;
          io_d = 1'b0;
          if (bo_d) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokBold; cnt = cnt + 4'd1;
          end
          if (io_d || co_d) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokDim; cnt = cnt + 4'd1;
          end
        end
      end else begin
        if (co_d || io_d) begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokStar; cnt = cnt + 4'd1;
          if (hc_d == 2'd2) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokStar; cnt = cnt + 4'd1;
          end
        end else if (hc_d == 2'd2) begin
          if (!bo_d) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokBold; cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokStar; cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokStar; cnt = cnt + 4'd1;
            bo_d = 1'b1;
          end else begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokStar;  cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokStar;  cnt = cnt + 4'd1;
            job_d.tok[cnt[2:0]] = mkah_pkg::TokReset; cnt = cnt + 4'd1;
            bo_d = 1'b0;
            if (io_d || co_d) begin
              job_d.tok[cnt[2:0]] = mkah_pkg::TokDim; cnt = cnt + 4'd1;
            end
          end
        end else begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokDim;   cnt = cnt + 4'd1;
          job_d.tok[cnt[2:0]] = mkah_pkg::TokStar;  cnt = cnt + 4'd1;
          job_d.tok[cnt[2:0]] = mkah_pkg::TokReset; cnt = cnt + 4'd1;
          if (bo_d) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokBold; cnt = cnt + 4'd1;
          end
          if (io_d || co_d) begin
            job_d.tok[cnt[2:0]] = mkah_pkg::TokDim; cnt = cnt + 4'd1;
          end
        end
      end
      hc_d = 2'd0;
    end

    if (color_q && func_i == mkah_pkg::FuncFeed && !skip) begin
      if (data_byte_i == mkah_pkg::ByteTick || data_byte_i == mkah_pkg::ByteStar) begin
        hb_d = (data_byte_i == mkah_pkg::ByteTick);
        hc_d = 2'd1;
        hl_d = ls_d;
        ls_d = 1'b0;
        // asterisks inside code go out at once
        if (data_byte_i == mkah_pkg::ByteStar && (co_d || io_d)) begin
          hc_d = 2'd0;
          job_d.tok[cnt[2:0]] = mkah_pkg::TokStar; cnt = cnt + 4'd1;
        end
      end else if (data_byte_i == mkah_pkg::ByteUnder && !co_d && !io_d) begin
        job_d.tok[cnt[2:0]] = mkah_pkg::TokDim;   cnt = cnt + 4'd1;
        job_d.tok[cnt[2:0]] = mkah_pkg::TokUnder; cnt = cnt + 4'd1;
        job_d.tok[cnt[2:0]] = mkah_pkg::TokReset; cnt = cnt + 4'd1;
        if (bo_d) begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokBold; cnt = cnt + 4'd1;
        end
        if (io_d || co_d) begin
          job_d.tok[cnt[2:0]] = mkah_pkg::TokDim; cnt = cnt + 4'd1;
        end
        ls_d = 1'b0;
      end else begin
        job_d.tok[cnt[2:0]] = {1'b0, data_byte_i}; cnt = cnt + 4'd1;
        ls_d = (data_byte_i == mkah_pkg::ByteNewline);
      end
    end

    if (color_q && func_i == mkah_pkg::FuncFinish) begin
      if (bo_d || io_d || co_d) begin
        job_d.tok[cnt[2:0]] = mkah_pkg::TokReset; cnt = cnt + 4'd1;
      end
      bo_d = 1'b0;
      io_d = 1'b0;
      co_d = 1'b0;
      ls_d = 1'b1;
    end

    if (!color_q && func_i == mkah_pkg::FuncFeed) begin
      job_d.tok[cnt[2:0]] = {1'b0, data_byte_i}; cnt = cnt + 4'd1;
    end

    job_d.cnt = cnt;
  end

  // drop items that produce no bytes
  assign push_o = accept && (job_d.cnt != 4'd0);
  assign job_o  = job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b1;
      hb_q    <= 1'b0;
      hc_q    <= 2'd0;
      hl_q    <= 1'b0;
      ls_q    <= 1'b1;
      bo_q    <= 1'b0;
      io_q    <= 1'b0;
      co_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
      if (accept) begin
        hb_q <= hb_d;
        hc_q <= hc_d;
        hl_q <= hl_d;
        ls_q <= ls_d;
        bo_q <= bo_d;
        io_q <= io_d;
        co_q <= co_d;
      end
    end
  end

endmodule

/* rtl/mkah_queue.sv */
module mkah_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mkah_pkg::job_t push_job_i,
  output logic           ready_o,
  output logic           valid_o,
  output mkah_pkg::job_t head_o,
  input  logic           pop_i
);

  mkah_pkg::job_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/mkah_back.sv */
module mkah_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  mkah_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o
);

  logic [2:0]     tok_idx_q;
  logic [1:0]     byte_idx_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;
  mkah_pkg::tok_t cur;
  logic [7:0]     cur_byte;
  logic           tok_end;
  logic           job_end;
  logic           advance;

  assign cur     = job_i.tok[tok_idx_q];
  assign tok_end = !cur.esc || (byte_idx_q == 2'd3);
  assign job_end = tok_end && (({1'b0, tok_idx_q} + 4'd1) == job_i.cnt);
  assign advance = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && job_end;

  always_comb begin
    if (!cur.esc) begin
      cur_byte = cur.chr;
    end else begin
      case (byte_idx_q)
        2'd0:    cur_byte = mkah_pkg::ByteEsc;
        2'd1:    cur_byte = mkah_pkg::ByteBracket;
        2'd2:    cur_byte = cur.chr;
        default: cur_byte = mkah_pkg::ByteEm;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= cur_byte;
      out_last_q <= job_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_idx_q   <= 3'd0;
      byte_idx_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        if (job_end) begin
          tok_idx_q  <= 3'd0;
          byte_idx_q <= 2'd0;
        end else if (tok_end) begin
          tok_idx_q  <= tok_idx_q + 3'd1;
          byte_idx_q <= 2'd0;
        end else begin
          byte_idx_q <= byte_idx_q + 2'd1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule
